// ----- hw/rtl/maxpool_3x3_stride2_pad1_assert.svh -----
// Assertion macros for the pooling block's checker.
`ifndef MAXPOOL_3X3_STRIDE2_PAD1_ASSERT_SVH
`define MAXPOOL_3X3_STRIDE2_PAD1_ASSERT_SVH

// Check a property on the rising clock edge, skipped while reset is low.
`define MXP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define MXP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/mxp_pkg.sv -----
// Shared types, constants and helpers of the 3x3 stride-2 max pooling block.
`default_nettype none

package mxp_pkg;

    localparam int DATA_W       = 16;
    localparam int CFG_W        = 11;
    localparam int CNT_W        = 10;
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int MAX_CHANNELS = 1024;
    localparam int PART_DEPTH   = (MAX_WIDTH + 1) / 2;
    localparam int PART_AW      = $clog2(PART_DEPTH);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W    = 2;

    localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_HEIGHT  = 2'd0,
        REG_PLANE_WIDTH   = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } cfg_reg_t;

    // One horizontal window maximum on its way to the vertical combine.
    typedef struct packed {
        logic signed [DATA_W-1:0] hmax;
        logic [PART_AW-1:0]       col;
        logic                     first_row;
        logic                     odd_row;
        logic                     last_row;
        logic                     last_col;
        logic                     last_chan;
    } vop_t;

    function automatic logic signed [DATA_W-1:0] smax(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        smax = (a > b) ? a : b;
    endfunction

    // Zero reads as one, anything above the bound saturates.
    function automatic logic [CFG_W-1:0] clamp_cfg(
        input logic [CFG_W-1:0] v,
        input logic [CFG_W-1:0] hi
    );
        if (v == '0) begin
            clamp_cfg = CFG_W'(1);
        end else if (v > hi) begin
            clamp_cfg = hi;
        end else begin
            clamp_cfg = v;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mxp_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module mxp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mxp_front.sv -----
// Front end: configuration, position counters and horizontal window maximum.
`default_nettype none

module mxp_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mxp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mxp_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                s_tvalid,
    input  wire logic signed [mxp_pkg::DATA_W-1:0]   sample,
    input  wire logic                                q_ready,
    output logic                                     push,
    output mxp_pkg::vop_t                            push_op
);

    localparam logic [mxp_pkg::CFG_W-1:0] HI_H = mxp_pkg::CFG_W'(mxp_pkg::MAX_HEIGHT);
    localparam logic [mxp_pkg::CFG_W-1:0] HI_W = mxp_pkg::CFG_W'(mxp_pkg::MAX_WIDTH);
    localparam logic [mxp_pkg::CFG_W-1:0] HI_C = mxp_pkg::CFG_W'(mxp_pkg::MAX_CHANNELS);

    logic [mxp_pkg::CFG_W-1:0]          height_reg, height_next;
    logic [mxp_pkg::CFG_W-1:0]          width_reg, width_next;
    logic [mxp_pkg::CFG_W-1:0]          chans_reg, chans_next;
    logic [mxp_pkg::CNT_W-1:0]          col_reg, col_next;
    logic [mxp_pkg::CNT_W-1:0]          row_reg, row_next;
    logic [mxp_pkg::CNT_W-1:0]          chan_reg, chan_next;
    logic signed [mxp_pkg::DATA_W-1:0]  hrun_reg, hrun_next;

    logic                               accept;
    logic                               restart;
    logic                               last_col, last_row, last_chan;
    logic                               hdone;
    logic signed [mxp_pkg::DATA_W-1:0]  hval;
    logic signed [mxp_pkg::DATA_W-1:0]  hcomb;

    assign accept    = s_tvalid && q_ready;
    assign last_col  = ({1'b0, col_reg} + mxp_pkg::CFG_W'(1)) >= width_reg;
    assign last_row  = ({1'b0, row_reg} + mxp_pkg::CFG_W'(1)) >= height_reg;
    assign last_chan = ({1'b0, chan_reg} + mxp_pkg::CFG_W'(1)) >= chans_reg;

    always_comb begin
        height_next = height_reg;
        width_next  = width_reg;
        chans_next  = chans_reg;
        restart     = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_index)
                mxp_pkg::REG_PLANE_HEIGHT: begin
                    height_next = mxp_pkg::clamp_cfg(cfg_data, HI_H);
                    restart     = 1'b1;
                end
                mxp_pkg::REG_PLANE_WIDTH: begin
                    width_next = mxp_pkg::clamp_cfg(cfg_data, HI_W);
                    restart    = 1'b1;
                end
                mxp_pkg::REG_CHANNEL_COUNT: begin
                    chans_next = mxp_pkg::clamp_cfg(cfg_data, HI_C);
                    restart    = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // Pair columns: odd column closes a window and seeds the next one.
    always_comb begin
        hcomb = (col_reg == '0) ? sample : mxp_pkg::smax(hrun_reg, sample);
        if (col_reg[0]) begin
            hval      = mxp_pkg::smax(hrun_reg, sample);
            hdone     = 1'b1;
            hrun_next = sample;
        end else begin
            hval      = hcomb;
            hdone     = last_col;
            hrun_next = hcomb;
        end
    end

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        chan_next = chan_reg;
        if (last_col) begin
            col_next = '0;
            if (last_row) begin
                row_next  = '0;
                chan_next = last_chan ? '0 : chan_reg + mxp_pkg::CNT_W'(1);
            end else begin
                row_next = row_reg + mxp_pkg::CNT_W'(1);
            end
        end else begin
            col_next = col_reg + mxp_pkg::CNT_W'(1);
        end
    end

    assign push              = accept && hdone;
    assign push_op.hmax      = hval;
    assign push_op.col       = col_reg[mxp_pkg::CNT_W-1:1];
    assign push_op.first_row = (row_reg == '0);
    assign push_op.odd_row   = row_reg[0];
    assign push_op.last_row  = last_row;
    assign push_op.last_col  = last_col;
    assign push_op.last_chan = last_chan;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= mxp_pkg::CFG_W'(1);
            width_reg  <= mxp_pkg::CFG_W'(1);
            chans_reg  <= mxp_pkg::CFG_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
            chan_reg   <= '0;
            hrun_reg   <= mxp_pkg::MOST_NEG;
        end else begin
            height_reg <= height_next;
            width_reg  <= width_next;
            chans_reg  <= chans_next;
            if (restart) begin
                col_reg  <= '0;
                row_reg  <= '0;
                chan_reg <= '0;
                hrun_reg <= mxp_pkg::MOST_NEG;
            end else if (accept) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                chan_reg <= chan_next;
                hrun_reg <= hrun_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mxp_queue.sv -----
// Short FIFO of horizontal maxima between front end and back end.
`default_nettype none

module mxp_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire mxp_pkg::vop_t push_op,
    output logic               q_ready,
    input  wire logic          pop,
    output logic               q_valid,
    output mxp_pkg::vop_t      q_op
);

    mxp_pkg::vop_t                  slots [mxp_pkg::QUEUE_DEPTH];
    logic [mxp_pkg::QUEUE_AW-1:0]   wptr_reg, rptr_reg;
    logic [mxp_pkg::QUEUE_AW:0]     count_reg;
    logic                           do_push, do_pop;

    assign q_ready = (count_reg != (mxp_pkg::QUEUE_AW+1)'(mxp_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_op    = slots[rptr_reg];
    assign do_push = push && q_ready;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + mxp_pkg::QUEUE_AW'(1);
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + mxp_pkg::QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (mxp_pkg::QUEUE_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (mxp_pkg::QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mxp_back.sv -----
// Back end: vertical combine through the column partials RAM, result register.
`default_nettype none

module mxp_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               q_valid,
    input  wire mxp_pkg::vop_t                      q_op,
    output logic                                    pop,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic signed [mxp_pkg::DATA_W-1:0]       pooled_max,
    output logic                                    row_end,
    output logic                                    plane_end,
    output logic                                    frame_end
);

    mxp_pkg::vop_t                      b_op_reg;
    logic                               b_valid_reg;
    logic                               fwd_hit_reg;
    logic signed [mxp_pkg::DATA_W-1:0]  fwd_data_reg;
    logic [mxp_pkg::DATA_W-1:0]         rd_data;

    logic                               out_valid_reg;
    logic signed [mxp_pkg::DATA_W-1:0]  out_max_reg;
    logic                               out_row_reg, out_plane_reg, out_frame_reg;

    logic signed [mxp_pkg::DATA_W-1:0]  part;
    logic signed [mxp_pkg::DATA_W-1:0]  res;
    logic signed [mxp_pkg::DATA_W-1:0]  wdata;
    logic                               emit, wr;
    logic                               out_ready, b_fire, issue;

    // Bypass a write that lands in the same cycle as the read of that column.
    assign part = fwd_hit_reg ? fwd_data_reg : signed'(rd_data);

    always_comb begin
        if (b_op_reg.odd_row) begin
            res   = mxp_pkg::smax(part, b_op_reg.hmax);
            emit  = 1'b1;
            wr    = 1'b1;
            wdata = b_op_reg.hmax;
        end else begin
            res   = b_op_reg.first_row ? b_op_reg.hmax
                                       : mxp_pkg::smax(part, b_op_reg.hmax);
            emit  = b_op_reg.last_row;
            wr    = !b_op_reg.last_row;
            wdata = res;
        end
    end

    assign out_ready = !out_valid_reg || m_tready;
    assign b_fire    = b_valid_reg && (!emit || out_ready);
    assign issue     = q_valid && (!b_valid_reg || b_fire);
    assign pop       = issue;

    mxp_ram #(
        .WIDTH (mxp_pkg::DATA_W),
        .DEPTH (mxp_pkg::PART_DEPTH)
    ) u_partials (
        .aclk  (aclk),
        .we    (b_fire && wr),
        .waddr (b_op_reg.col),
        .wdata (wdata),
        .re    (issue),
        .raddr (q_op.col),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (issue) begin
            b_op_reg     <= q_op;
            fwd_hit_reg  <= b_fire && wr && (b_op_reg.col == q_op.col);
            fwd_data_reg <= wdata;
        end
        if (b_fire && emit) begin
            out_max_reg   <= res;
            out_row_reg   <= b_op_reg.last_col;
            out_plane_reg <= b_op_reg.last_col && b_op_reg.last_row;
            out_frame_reg <= b_op_reg.last_col && b_op_reg.last_row && b_op_reg.last_chan;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (issue) begin
                b_valid_reg <= 1'b1;
            end else if (b_fire) begin
                b_valid_reg <= 1'b0;
            end
            if (b_fire && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign pooled_max = out_max_reg;
    assign row_end    = out_row_reg;
    assign plane_end  = out_plane_reg;
    assign frame_end  = out_frame_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/maxpool_3x3_stride2_pad1.sv -----
// Top level of the streaming 3x3 stride-2 max pooling block.
`default_nettype none

// Streaming 3x3 max pooling, stride 2, one-sample border that never wins.
// Samples enter in raster order (column, then row, then channel plane), one
// request per clock when m_tready stays high. The result of a window passes
// the queue, the back-end stage register and the output register, which
// drives m_tvalid. Throughput is one sample per cycle while m_tready stays
// high; it is set by the column partials RAM, which serves one read and one
// write per horizontal window maximum, with a bypass for a column read in the
// cycle it is written. A four-entry queue separates the counters and the
// horizontal maximum from the RAM stage, so each side stalls on its own. A
// write to any configuration register restarts the frame at channel 0, row 0,
// column 0; write registers only while no request is in flight. A register
// value of 0 is taken as 1 and values above 1024 saturate to 1024.
module maxpool_3x3_stride2_pad1 (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [mxp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mxp_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [15:0]                        s_tdata,  // [15:0] sample
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [15:0]                             m_tdata,  // [15:0] pooled_max
    output logic [1:0]                              m_tuser,  // [0] row_end, [1] plane_end
    output logic                                    m_tlast   // frame_end
);

    mxp_pkg::vop_t                      push_op, q_op;
    logic                               push, q_ready, q_valid, pop;
    logic signed [mxp_pkg::DATA_W-1:0]  pooled_max;
    logic                               row_end, plane_end, frame_end;

    mxp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .sample    (signed'(s_tdata)),
        .q_ready   (q_ready),
        .push      (push),
        .push_op   (push_op)
    );

    mxp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .q_ready (q_ready),
        .pop     (pop),
        .q_valid (q_valid),
        .q_op    (q_op)
    );

    mxp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_op       (q_op),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .pooled_max (pooled_max),
        .row_end    (row_end),
        .plane_end  (plane_end),
        .frame_end  (frame_end)
    );

    assign s_tready = q_ready;
    assign m_tdata  = pooled_max;
    assign m_tuser  = {plane_end, row_end};
    assign m_tlast  = frame_end;

endmodule

`default_nettype wire

// ----- hw/rtl/mxp_checker.sv -----
// Port-level checker for the pooling block, bound to the top level.
`default_nettype none

`include "maxpool_3x3_stride2_pad1_assert.svh"

module mxp_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           cfg_wr_en,
    input wire logic [mxp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic [mxp_pkg::CFG_W-1:0]      cfg_data,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [15:0]                    s_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [15:0]                    m_tdata,
    input wire logic [1:0]                     m_tuser,
    input wire logic                           m_tlast
);

    // A stalled result keeps its value.
    `MXP_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // The last result of a frame also closes its plane and its row.
    `MXP_ASSERT(a_frame_flags, aclk, aresetn, m_tvalid && m_tlast |-> m_tuser[1] && m_tuser[0], "frame end without plane and row end")

    // A plane end is always a row end.
    `MXP_ASSERT(a_plane_row, aclk, aresetn, m_tvalid && m_tuser[1] |-> m_tuser[0], "plane end without row end")

    // Reset drops any pending result.
    `MXP_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind maxpool_3x3_stride2_pad1 mxp_checker u_mxp_checker (.*);

`default_nettype wire
